>>> design/frwa_pkg.sv
// frwa_pkg: shared constants and types of the fair reader/writer arbiter.
// No dependencies; used by frwa_ram and fifo_fair_reader_writer_arbiter.
package frwa_pkg;

	localparam int TAG_W = 8;
	localparam int RC_W  = 8;
	localparam int ENTRY_W = TAG_W + 1;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int MAX_READERS_DEF = 255;

	localparam logic [1:0] OP_REQ_READ  = 2'd0;
	localparam logic [1:0] OP_REQ_WRITE = 2'd1;
	localparam logic [1:0] OP_END_READ  = 2'd2;
	localparam logic [1:0] OP_END_WRITE = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NO_HOLDER = 2'd2;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_GRANT  = 1'b1;

	// one queued request: write flag above the tag
	typedef struct packed {
		logic             wr;
		logic [TAG_W-1:0] tag;
	} entry_t;

endpackage

>>> design/fifo_fair_reader_writer_arbiter.sv
// fifo_fair_reader_writer_arbiter: top level, admission sequencer around the wait queue.
// Depends on frwa_pkg and frwa_ram.
//
// channel   dir  handshake                 payload
// command   in   start && !busy            operation[1:0], requester[7:0]
// result    out  strobe (one cycle, no     item_kind, granted_requester, granted_write,
//                back pressure)            status, readers_active, last
//
// Sequence: a command passes through accept, the queue head read, one grant per cycle
//   for each waiter that it releases, then the status beat.
//   After a reader grant the next head is read from the wait queue RAM at once.
// busy is high from the cycle after accept until the status beat is on the ports;
//   the next command may be accepted while that beat is shown.
// Reset (arst_n low) clears counters, flags and sequencer; queue contents are not cleared.
// The receiver cannot stall: every beat is taken in the cycle strobe is high.
module fifo_fair_reader_writer_arbiter #(
	parameter int QUEUE_DEPTH = frwa_pkg::QUEUE_DEPTH_DEF,
	parameter int MAX_READERS = frwa_pkg::MAX_READERS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                operation,
	input  logic [frwa_pkg::TAG_W-1:0] requester,
	output logic                      strobe,
	output logic                      item_kind,
	output logic [frwa_pkg::TAG_W-1:0] granted_requester,
	output logic                      granted_write,
	output logic [1:0]                status,
	output logic [frwa_pkg::RC_W-1:0]  readers_active,
	output logic                      last
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C   = CW'(QUEUE_DEPTH);
	localparam logic [CW:0]   DEPTH_X   = (CW+1)'(QUEUE_DEPTH);
	localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
	localparam logic [frwa_pkg::RC_W-1:0] MAX_RC = frwa_pkg::RC_W'(MAX_READERS);

	// sequencer states
	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_READ   = 2'd1; // head read in flight
	localparam logic [1:0] S_EVAL   = 2'd2; // head entry on rd_data
	localparam logic [1:0] S_STATUS = 2'd3; // writer just admitted, close out

	logic [1:0]                state_q;
	logic [AW-1:0]             head_q;
	logic [CW-1:0]             count_q;
	logic [frwa_pkg::RC_W-1:0] rc_q;
	logic                      wa_q;
	logic [1:0]                op_status_q;

	logic                      strobe_q;
	logic                      kind_q;
	logic [frwa_pkg::TAG_W-1:0] tag_q;
	logic                      gw_q;
	logic [1:0]                status_q;
	logic [frwa_pkg::RC_W-1:0] ra_q;
	logic                      last_q;

	// queue RAM hookup
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	frwa_pkg::entry_t     wr_entry;
	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic [frwa_pkg::ENTRY_W-1:0] rd_data;
	frwa_pkg::entry_t     head_entry;

	logic          accept;
	logic          is_req;
	logic          full;
	logic [CW:0]   tail_sum;
	logic [AW-1:0] tail_addr;
	logic [AW-1:0] head_nxt;
	logic          admit;

	assign accept = start && (state_q == S_IDLE);
	assign is_req = (operation == frwa_pkg::OP_REQ_READ) ||
	                (operation == frwa_pkg::OP_REQ_WRITE);
	assign full   = (count_q == DEPTH_C);

	// tail = (head + count) mod depth; sum stays below twice the depth
	assign tail_sum  = (CW+1)'(head_q) + (CW+1)'(count_q);
	assign tail_addr = (tail_sum >= DEPTH_X) ? AW'(tail_sum - DEPTH_X) : AW'(tail_sum);
	assign head_nxt  = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;

	assign head_entry = frwa_pkg::entry_t'(rd_data);

	// head may enter: writer needs an idle resource, reader needs no writer and room
	always_comb begin
		admit = 1'b0;
		if (state_q == S_EVAL && count_q != '0 && !wa_q) begin
			if (head_entry.wr) begin
				admit = (rc_q == '0);
			end else begin
				admit = (rc_q < MAX_RC);
			end
		end
	end

	assign wr_en        = accept && is_req && !full;
	assign wr_addr      = tail_addr;
	assign wr_entry.wr  = (operation == frwa_pkg::OP_REQ_WRITE);
	assign wr_entry.tag = requester;

	// after a reader grant, fetch the next head right away
	assign rd_en   = (state_q == S_READ) || (admit && !head_entry.wr);
	assign rd_addr = (state_q == S_READ) ? head_q : head_nxt;

	frwa_ram #(
		.DEPTH(QUEUE_DEPTH),
		.WIDTH(frwa_pkg::ENTRY_W)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_entry),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			count_q  <= '0;
			rc_q     <= '0;
			wa_q     <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_READ;
						unique case (operation)
							frwa_pkg::OP_REQ_READ, frwa_pkg::OP_REQ_WRITE: begin
								if (!full) begin
									count_q <= count_q + 1'b1;
								end
							end
							frwa_pkg::OP_END_READ: begin
								if (rc_q != '0) begin
									rc_q <= rc_q - 1'b1;
								end
							end
							default: begin
								wa_q <= 1'b0;
							end
						endcase
					end
				end
				S_READ: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					strobe_q <= 1'b1;
					if (admit) begin
						head_q  <= head_nxt;
						count_q <= count_q - 1'b1;
						if (head_entry.wr) begin
							wa_q    <= 1'b1;
							state_q <= S_STATUS;
						end else begin
							rc_q <= rc_q + 1'b1;
						end
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					strobe_q <= 1'b1;
					state_q  <= S_IDLE;
				end
			endcase
		end
	end

	// payload: command status and result beat
	always_ff @(posedge clk) begin
		if (accept) begin
			op_status_q <= frwa_pkg::ST_OK;
			unique case (operation)
				frwa_pkg::OP_REQ_READ, frwa_pkg::OP_REQ_WRITE: begin
					if (full) begin
						op_status_q <= frwa_pkg::ST_FULL;
					end
				end
				frwa_pkg::OP_END_READ: begin
					if (rc_q == '0) begin
						op_status_q <= frwa_pkg::ST_NO_HOLDER;
					end
				end
				default: begin
					if (!wa_q) begin
						op_status_q <= frwa_pkg::ST_NO_HOLDER;
					end
				end
			endcase
		end
		if (admit) begin
			kind_q   <= frwa_pkg::KIND_GRANT;
			tag_q    <= head_entry.tag;
			gw_q     <= head_entry.wr;
			status_q <= frwa_pkg::ST_OK;
			ra_q     <= head_entry.wr ? rc_q : rc_q + 1'b1;
			last_q   <= 1'b0;
		end else if (state_q == S_EVAL || state_q == S_STATUS) begin
			kind_q   <= frwa_pkg::KIND_STATUS;
			tag_q    <= '0;
			gw_q     <= 1'b0;
			status_q <= op_status_q;
			ra_q     <= rc_q;
			last_q   <= 1'b1;
		end
	end

	assign busy              = (state_q != S_IDLE);
	assign strobe            = strobe_q;
	assign item_kind         = kind_q;
	assign granted_requester = tag_q;
	assign granted_write     = gw_q;
	assign status            = status_q;
	assign readers_active    = ra_q;
	assign last              = last_q;

	// a writer holding the resource excludes all readers
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		wa_q |-> (rc_q == '0))
		else $error("writer active with readers admitted");

	// the sequencer returns to idle only with the closing status beat
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (strobe && last && item_kind == frwa_pkg::KIND_STATUS))
		else $error("command closed without status beat");

	// a writer grant ends the run: the status beat follows at once
	a_wr_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && item_kind == frwa_pkg::KIND_GRANT && granted_write) |=> (strobe && last))
		else $error("grant after writer admission");

	// a request made while the queue is full leaves occupancy at its depth
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_req && full) |=> (count_q == DEPTH_C))
		else $error("dropped request changed occupancy");

endmodule

>>> design/frwa_ram.sv
// frwa_ram: wait queue storage, one write port, one read port, registered read.
// Depends on frwa_pkg for the default entry width.
module frwa_ram #(
	parameter int DEPTH = frwa_pkg::QUEUE_DEPTH_DEF,
	parameter int WIDTH = frwa_pkg::ENTRY_W
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
